FILE: hdl/bql_pkg.sv
// Shared widths, register codes and data types of the multichannel biquad low-pass filter.
package bql_pkg;

  localparam int unsigned ChW      = 3;
  localparam int unsigned SampW    = 16;
  localparam int unsigned CoefW    = 20;
  localparam int unsigned FracW    = 16;
  localparam int unsigned NumRegs  = 5;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned ProdW    = CoefW + SampW;
  localparam int unsigned AccW     = ProdW + 4;
  localparam int unsigned QuotW    = AccW - FracW;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [RegIdxW-1:0] RegB0 = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegB1 = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegB2 = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegA1 = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegA2 = RegIdxW'(4);

  localparam logic signed [AccW-1:0]  RoundBias = AccW'(1) << (FracW - 1);
  localparam logic signed [SampW-1:0] SampMax   = {1'b0, {(SampW - 1){1'b1}}};
  localparam logic signed [SampW-1:0] SampMin   = {1'b1, {(SampW - 1){1'b0}}};

  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } coef_t;

  // One history entry: x1, x2 are past inputs, y1, y2 past outputs.
  typedef struct packed {
    logic signed [SampW-1:0] x1;
    logic signed [SampW-1:0] x2;
    logic signed [SampW-1:0] y1;
    logic signed [SampW-1:0] y2;
  } hist_t;

  typedef struct packed {
    logic                    ok;
    logic [ChW-1:0]          ch;
    logic signed [SampW-1:0] x;
    hist_t                   hist;
  } mac_op_t;

  typedef struct packed {
    logic                    ok;
    logic [ChW-1:0]          ch;
    logic signed [SampW-1:0] y;
    hist_t                   wb;
  } mac_res_t;

  typedef struct packed {
    logic [ChW-1:0]          ch;
    logic signed [SampW-1:0] filtered;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

FILE: hdl/bql_if.sv
// Valid/ready channel interfaces for input samples and filtered results.
interface bql_in_if;
  logic                            valid;
  logic                            ready;
  logic [bql_pkg::ChW-1:0]         channel;
  logic signed [bql_pkg::SampW-1:0] sample;
  logic                            preload;

  modport source(output valid, channel, sample, preload, input ready);
  modport sink(input valid, channel, sample, preload, output ready);
endinterface

interface bql_out_if;
  logic                            valid;
  logic                            ready;
  logic [bql_pkg::ChW-1:0]         out_channel;
  logic signed [bql_pkg::SampW-1:0] filtered;

  modport source(output valid, out_channel, filtered, input ready);
  modport sink(input valid, out_channel, filtered, output ready);
endinterface

FILE: hdl/bql_hist_mem.sv
// Per-channel filter history memory with registered synchronous read and valid flags.
module bql_hist_mem #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bql_pkg::ChW-1:0]  rd_ch_i,
  input  logic                     wr_en_i,
  input  logic [bql_pkg::ChW-1:0]  wr_ch_i,
  input  bql_pkg::hist_t           wr_data_i,
  output bql_pkg::hist_t           rd_data_o
);

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned Depth = 2 ** AddrW;

  bql_pkg::hist_t    mem [Depth];
  bql_pkg::hist_t    rd_q;
  logic [Depth-1:0]  vld_q;
  logic              rd_vld_q;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;

  assign rd_addr = AddrW'(rd_ch_i);
  assign wr_addr = AddrW'(wr_ch_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= wr_data_i;
    end
    rd_q <= mem[rd_addr];
  end

  // An entry never written since reset reads as zero history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: hdl/bql_mac.sv
// Two-stage multiply and sum datapath with rounding and saturation.
module bql_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  bql_pkg::mac_op_t    op_i,
  input  bql_pkg::coef_t      coef_i,
  output logic                vld_o,
  output bql_pkg::mac_res_t   res_o
);

  localparam int unsigned ProdW = bql_pkg::ProdW;
  localparam int unsigned AccW  = bql_pkg::AccW;
  localparam int unsigned QuotW = bql_pkg::QuotW;
  localparam int unsigned SampW = bql_pkg::SampW;

  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q;
  logic                    vld_q;
  logic                    ok_q;
  logic [bql_pkg::ChW-1:0] ch_q;
  logic signed [SampW-1:0] x_q, x1_q, y1_q;

  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  rnd;
  logic signed [QuotW-1:0] quot;
  logic                    ovf_pos, ovf_neg;
  logic signed [SampW-1:0] sat;
  logic signed [SampW-1:0] y;

  always_ff @(posedge clk_i) begin
    p0_q <= $signed(coef_i.b0) * $signed(op_i.x);
    p1_q <= $signed(coef_i.b1) * $signed(op_i.hist.x1);
    p2_q <= $signed(coef_i.b2) * $signed(op_i.hist.x2);
    p3_q <= $signed(coef_i.a1) * $signed(op_i.hist.y1);
    p4_q <= $signed(coef_i.a2) * $signed(op_i.hist.y2);
    ok_q <= op_i.ok;
    ch_q <= op_i.ch;
    x_q  <= op_i.x;
    x1_q <= op_i.hist.x1;
    y1_q <= op_i.hist.y1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Adding half an LSB and flooring rounds halves towards plus infinity.
  assign acc  = AccW'(p0_q) + AccW'(p1_q) + AccW'(p2_q) - AccW'(p3_q) - AccW'(p4_q);
  assign rnd  = acc + bql_pkg::RoundBias;
  assign quot = rnd[AccW-1:bql_pkg::FracW];

  assign ovf_pos = !quot[QuotW-1] && (|quot[QuotW-2:SampW-1]);
  assign ovf_neg = quot[QuotW-1] && !(&quot[QuotW-2:SampW-1]);

  always_comb begin
    if (ovf_pos) begin
      sat = bql_pkg::SampMax;
    end else if (ovf_neg) begin
      sat = bql_pkg::SampMin;
    end else begin
      sat = quot[SampW-1:0];
    end
  end

  assign y = ok_q ? sat : '0;

  assign vld_o       = vld_q;
  assign res_o.ok    = ok_q;
  assign res_o.ch    = ch_q;
  assign res_o.y     = y;
  assign res_o.wb.x1 = x_q;
  assign res_o.wb.x2 = x1_q;
  assign res_o.wb.y1 = y;
  assign res_o.wb.y2 = y1_q;

endmodule

FILE: hdl/bql_out_fifo.sv
// Four-entry result queue that decouples the pipeline from the result receiver.
module bql_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bql_pkg::result_t      push_data_i,
  input  logic                  pop_i,
  output bql_pkg::result_t      data_o,
  output bql_pkg::fifo_stat_t   stat_o
);

  localparam int unsigned PtrW = bql_pkg::FifoPtrW;
  localparam int unsigned CntW = bql_pkg::FifoCntW;

  bql_pkg::result_t  buf_q [bql_pkg::FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  assign data_o       = buf_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(bql_pkg::FifoDepth));

endmodule

FILE: hdl/multichannel_biquad_lowpass.sv
// Top level of the multichannel direct-form-I biquad low-pass filter.
//
// Samples arrive on smp_i, each tagged with a channel and a preload flag;
// every transaction on smp_i gives exactly one transaction on res_o, in order.
// The five shared Q4.16 coefficients are written through the cfg_* port; the user
// must write them only while the block is idle, which the block does not enforce.
// A sample passes through the registered history read, the five registered
// multipliers and the final sum, which is pushed into the result queue; the
// history update is written back at the end.
// Throughput: one sample per cycle unless the input is stalled. A sample for the
// same in-range channel as the sample accepted on the previous cycle waits,
// because its history depends on an output still in the sum stage; once that
// output is in the write-back register, it is forwarded from there.
// Results wait in a four-entry queue. The input is ready only while fewer
// than four results are in flight or queued, so a stalled receiver stops the
// input after at most four transactions and no result is lost.
// Reset clears the coefficients to zero and marks every channel history as
// zero through per-entry valid flags; no clearing pass is needed.
// Channels at or above CHANNELS return zero and leave all state untouched.
module multichannel_biquad_lowpass #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bql_pkg::RegIdxW-1:0]    cfg_idx_i,
  input  logic [bql_pkg::CoefW-1:0]      cfg_wdata_i,
  bql_in_if.sink                         smp_i,
  bql_out_if.source                      res_o
);

  localparam int unsigned ChW    = bql_pkg::ChW;
  localparam int unsigned ChCmpW = $clog2(CHANNELS + 1) + ChW;
  localparam int unsigned CntW   = bql_pkg::FifoCntW;

  bql_pkg::coef_t       coef_q;

  logic                 acc_in;
  logic                 pop;
  logic                 hazard;
  logic                 in_range;
  logic [CntW-1:0]      cnt_q;

  logic                 s1_vld_q;
  logic                 s1_ok_q;
  logic                 s1_pre_q;
  logic [ChW-1:0]       s1_ch_q;
  logic signed [bql_pkg::SampW-1:0] s1_x_q;

  bql_pkg::hist_t       rd_hist;
  bql_pkg::hist_t       s1_hist;
  bql_pkg::mac_op_t     mac_op;
  logic                 mac_vld;
  bql_pkg::mac_res_t    mac_res;
  logic                 wr_en;

  logic                 wb_vld_q;
  logic [ChW-1:0]       wb_ch_q;
  bql_pkg::hist_t       wb_data_q;

  bql_pkg::result_t     push_data;
  bql_pkg::result_t     head;
  bql_pkg::fifo_stat_t  fifo_stat;

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bql_pkg::RegB0: coef_q.b0 <= $signed(cfg_wdata_i);
        bql_pkg::RegB1: coef_q.b1 <= $signed(cfg_wdata_i);
        bql_pkg::RegB2: coef_q.b2 <= $signed(cfg_wdata_i);
        bql_pkg::RegA1: coef_q.a1 <= $signed(cfg_wdata_i);
        bql_pkg::RegA2: coef_q.a2 <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign in_range = ChCmpW'(smp_i.channel) < ChCmpW'(CHANNELS);
  assign hazard   = s1_vld_q && s1_ok_q && (smp_i.channel == s1_ch_q);
  assign smp_i.ready = (cnt_q < CntW'(bql_pkg::FifoDepth)) && !hazard;
  assign acc_in   = smp_i.valid && smp_i.ready;
  assign pop      = res_o.valid && res_o.ready;

  // Results in flight or queued; bounded by the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CntW'(acc_in) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      wb_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= acc_in;
      wb_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ch_q   <= smp_i.channel;
    s1_x_q    <= smp_i.sample;
    s1_pre_q  <= smp_i.preload;
    s1_ok_q   <= in_range;
    wb_ch_q   <= mac_res.ch;
    wb_data_q <= mac_res.wb;
  end

  bql_hist_mem #(
    .CHANNELS (CHANNELS)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_ch_i   (smp_i.channel),
    .wr_en_i   (wr_en),
    .wr_ch_i   (mac_res.ch),
    .wr_data_i (mac_res.wb),
    .rd_data_o (rd_hist)
  );

  // A preload sets all history to the sample. Else, as the memory read overlapped
  // the last write-back, that entry comes from the write-back register on a match.
  always_comb begin
    if (s1_pre_q) begin
      s1_hist = '{x1: s1_x_q, x2: s1_x_q, y1: s1_x_q, y2: s1_x_q};
    end else if (wb_vld_q && (wb_ch_q == s1_ch_q)) begin
      s1_hist = wb_data_q;
    end else begin
      s1_hist = rd_hist;
    end
  end

  assign mac_op.ok   = s1_ok_q;
  assign mac_op.ch   = s1_ch_q;
  assign mac_op.x    = s1_x_q;
  assign mac_op.hist = s1_hist;

  bql_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld_q),
    .op_i   (mac_op),
    .coef_i (coef_q),
    .vld_o  (mac_vld),
    .res_o  (mac_res)
  );

  assign wr_en = mac_vld && mac_res.ok;

  assign push_data.ch       = mac_res.ch;
  assign push_data.filtered = mac_res.y;

  bql_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (mac_vld),
    .push_data_i (push_data),
    .pop_i       (pop),
    .data_o      (head),
    .stat_o      (fifo_stat)
  );

  assign res_o.valid       = !fifo_stat.empty;
  assign res_o.out_channel = head.ch;
  assign res_o.filtered    = head.filtered;

`ifndef SYNTHESIS
  a_push_two_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |-> ##2 mac_vld)
    else $error("accepted sample did not reach the result queue two cycles later");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_vld |-> (!fifo_stat.full || pop))
    else $error("result pushed into a full queue");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(bql_pkg::FifoDepth))
    else $error("results in flight exceed the queue depth");

  a_no_back_to_back_same_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && s1_vld_q && s1_ok_q) |-> (smp_i.channel != s1_ch_q))
    else $error("same channel accepted while its history is still in the sum stage");
`endif

endmodule

FILE: verif/tb_multichannel_biquad_lowpass.sv
// Self-checking testbench for the multichannel direct-form-I biquad low-pass filter.
module tb_multichannel_biquad_lowpass;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ChW        = bql_pkg::ChW;
  localparam int unsigned SampW      = bql_pkg::SampW;
  localparam int unsigned CoefW      = bql_pkg::CoefW;
  localparam int unsigned FracW      = bql_pkg::FracW;
  localparam int unsigned NumRegs    = bql_pkg::NumRegs;
  localparam int unsigned RegIdxW    = bql_pkg::RegIdxW;
  localparam int unsigned NumCh      = 8;
  localparam int          StallLimit = 2000;
  localparam int          SettleCyc  = 6;
  localparam int          HoldCyc    = 150;

  typedef struct packed {
    logic [ChW-1:0]          ch;
    logic signed [SampW-1:0] x;
    logic                    preload;
  } sample_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RegIdxW-1:0]  cfg_idx_i;
  logic [CoefW-1:0]    cfg_wdata_i;

  bql_in_if  smp_if();
  bql_out_if res_if();

  multichannel_biquad_lowpass #(
    .CHANNELS(NumCh)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .smp_i      (smp_if),
    .res_o      (res_if)
  );

  always #1 clk_i = ~clk_i;

  // Filter state as the testbench sees it.
  logic signed [CoefW-1:0] coef_q [NumRegs];
  bql_pkg::hist_t          hist_q [NumCh];

  sample_item_t      pending_items[$];
  bql_pkg::result_t  expected_results[$];

  int   err_count;
  int   items_in;
  int   results_out;
  int   stall_cycles;
  logic in_accepted;
  int   hold_left;
  logic hold_done;

  // Rounds half towards plus infinity, saturates, and shifts the channel history.
  function automatic bql_pkg::result_t filter_sample(input sample_item_t it);
    bql_pkg::result_t r;
    bql_pkg::hist_t   h;
    longint           acc;
    longint           q;
    r.ch       = it.ch;
    r.filtered = '0;
    if (it.ch < NumCh) begin
      h = hist_q[it.ch];
      if (it.preload) begin
        h = '{x1: it.x, x2: it.x, y1: it.x, y2: it.x};
      end
      acc = longint'($signed(coef_q[bql_pkg::RegB0])) * longint'($signed(it.x))
          + longint'($signed(coef_q[bql_pkg::RegB1])) * longint'($signed(h.x1))
          + longint'($signed(coef_q[bql_pkg::RegB2])) * longint'($signed(h.x2))
          - longint'($signed(coef_q[bql_pkg::RegA1])) * longint'($signed(h.y1))
          - longint'($signed(coef_q[bql_pkg::RegA2])) * longint'($signed(h.y2));
      q = (acc + 64'sd32768) >>> FracW;
      if (q > 64'sd32767) q = 64'sd32767;
      if (q < -64'sd32768) q = -64'sd32768;
      r.filtered  = q[SampW-1:0];
      hist_q[it.ch] = '{x1: it.x, x2: h.x1, y1: r.filtered, y2: h.y1};
    end
    return r;
  endfunction

  // Sampling, prediction, checking and the stall watchdog, all at the rising edge.
  always @(posedge clk_i) begin
    sample_item_t     it;
    bql_pkg::result_t exp_res;
    if (rst_ni) begin
      in_accepted = smp_if.valid && smp_if.ready;

      if (in_accepted || (res_if.valid && res_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end

      if (cfg_we_i && cfg_idx_i < NumRegs) begin
        coef_q[cfg_idx_i] = cfg_wdata_i;
      end

      if (res_if.valid && res_if.ready) begin
        results_out++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: channel %0d, filtered %0d",
                 res_if.out_channel, res_if.filtered);
          err_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (res_if.out_channel !== exp_res.ch) begin
            $error("out_channel mismatch: expected %0d, got %0d",
                   exp_res.ch, res_if.out_channel);
            err_count++;
          end
          if (res_if.filtered !== exp_res.filtered) begin
            $error("filtered mismatch: expected %0d, got %0d",
                   exp_res.filtered, res_if.filtered);
            err_count++;
          end
        end
      end

      if (in_accepted) begin
        it.ch      = smp_if.channel;
        it.x       = smp_if.sample;
        it.preload = smp_if.preload;
        expected_results.push_back(filter_sample(it));
        void'(pending_items.pop_front());
        items_in++;
      end
    end
  end

  // Sample driver: holds a transaction until it is taken, idles at random otherwise.
  always @(negedge clk_i) begin
    logic idle;
    idle = !(items_in >= 700 && items_in < 1000) && ($urandom_range(99) < 14);
    if (rst_ni && !(smp_if.valid && !in_accepted)) begin
      if (pending_items.size() > 0 && !idle) begin
        smp_if.valid   <= 1'b1;
        smp_if.channel <= pending_items[0].ch;
        smp_if.sample  <= pending_items[0].x;
        smp_if.preload <= pending_items[0].preload;
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off while the sender still has plenty queued.
  always @(negedge clk_i) begin
    logic rdy;
    if (hold_left > 0) begin
      rdy = 1'b0;
      hold_left--;
    end else if (!hold_done && results_out >= 400 && pending_items.size() > 50) begin
      hold_done = 1'b1;
      hold_left = HoldCyc;
      rdy       = 1'b0;
    end else begin
      rdy = (results_out >= 1300 && results_out < 1600) || ($urandom_range(99) >= 14);
    end
    res_if.ready <= rdy;
  end

  task automatic write_coef(input logic [RegIdxW-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CoefW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_coefs(input int b0, input int b1, input int b2, input int a1,
                           input int a2);
    write_coef(bql_pkg::RegB0, b0);
    write_coef(bql_pkg::RegB1, b1);
    write_coef(bql_pkg::RegB2, b2);
    write_coef(bql_pkg::RegA1, a1);
    write_coef(bql_pkg::RegA2, a2);
  endtask

  task automatic queue_item(input int ch, input int x, input logic pre);
    sample_item_t it;
    it.ch      = ChW'(ch);
    it.x       = SampW'(x);
    it.preload = pre;
    pending_items.push_back(it);
  endtask

  function automatic int random_sample();
    case ($urandom_range(9))
      0:       return int'(bql_pkg::SampMax);
      1:       return int'(bql_pkg::SampMin);
      2, 3, 4: return int'($urandom_range(512)) - 256;
      default: return int'($signed(SampW'($urandom_range(16'hFFFF))));
    endcase
  endfunction

  // Mostly runs that preload a channel and then follow a drifting level on it,
  // mixed with loose samples on the same, the alternate or any channel.
  task automatic queue_random_items(input int count);
    int left;
    int run;
    int lvl;
    int ch;
    int last_ch;
    int other_ch;
    left     = count;
    last_ch  = 0;
    other_ch = 1;
    while (left > 0) begin
      if ($urandom_range(99) < 55) begin
        ch  = $urandom_range(NumCh - 1);
        lvl = random_sample();
        queue_item(ch, lvl, 1'b1);
        left--;
        run = $urandom_range(12, 2);
        while (run > 0 && left > 0) begin
          lvl = lvl + int'($urandom_range(4096)) - 2048;
          if (lvl > 32767) lvl = 32767;
          if (lvl < -32768) lvl = -32768;
          queue_item(ch, lvl, 1'b0);
          run--;
          left--;
        end
      end else begin
        case ($urandom_range(2))
          0:       ch = $urandom_range(NumCh - 1);
          1:       ch = last_ch;
          default: ch = other_ch;
        endcase
        queue_item(ch, random_sample(), $urandom_range(9) == 0);
        left--;
      end
      if (ch != last_ch) begin
        other_ch = last_ch;
        last_ch  = ch;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  initial begin
    int a2;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    smp_if.valid    = 1'b0;
    smp_if.channel  = '0;
    smp_if.sample   = '0;
    smp_if.preload  = 1'b0;
    res_if.ready    = 1'b0;
    err_count       = 0;
    items_in        = 0;
    results_out     = 0;
    stall_cycles    = 0;
    in_accepted     = 1'b0;
    hold_left       = 0;
    hold_done       = 1'b0;
    foreach (coef_q[i]) coef_q[i] = '0;
    foreach (hist_q[i]) hist_q[i] = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Coefficients still at reset: every output is zero.
    queue_item(0, 32767, 1'b1);
    queue_item(7, -32768, 1'b0);
    queue_random_items(40);
    wait_drained();

    // A gain of one half exposes rounding of exact halves in both signs.
    set_coefs(32768, 0, 0, 0, 0);
    queue_item(1, 1, 1'b1);
    queue_item(1, -1, 1'b0);
    queue_item(2, 3, 1'b0);
    queue_item(2, -3, 1'b0);
    queue_random_items(60);
    wait_drained();

    // Every tap in use; back-to-back and every-other transactions on one channel.
    set_coefs(65536, 32768, -16384, -32768, 8192);
    queue_item(3, 1000, 1'b1);
    queue_item(3, 2000, 1'b0);
    queue_item(3, -2000, 1'b0);
    queue_item(4, 500, 1'b0);
    queue_item(3, 100, 1'b0);
    queue_item(5, 32767, 1'b1);
    queue_item(5, -32768, 1'b0);
    queue_item(6, 0, 1'b1);
    queue_random_items(200);
    wait_drained();

    // Largest positive coefficients: saturation at both ends.
    set_coefs(524287, 524287, 524287, 524287, 524287);
    queue_item(0, 32767, 1'b1);
    queue_item(0, -32768, 1'b0);
    queue_item(1, -32768, 1'b1);
    queue_random_items(150);
    wait_drained();

    // Most negative coefficients.
    set_coefs(-524288, -524288, -524288, -524288, -524288);
    queue_item(2, 32767, 1'b1);
    queue_item(2, -32768, 1'b0);
    queue_random_items(150);
    wait_drained();

    repeat (3) begin
      // A stable low-pass section, so that outputs mostly stay in range.
      a2 = $urandom_range(58982, 3277);
      set_coefs($urandom_range(16384), $urandom_range(16384), $urandom_range(16384),
                -int'($urandom_range(65536 + a2 - 2000)), a2);
      queue_random_items(300);
      wait_drained();

      set_coefs($urandom_range((1 << CoefW) - 1), $urandom_range((1 << CoefW) - 1),
                $urandom_range((1 << CoefW) - 1), $urandom_range((1 << CoefW) - 1),
                $urandom_range((1 << CoefW) - 1));
      queue_random_items(150);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
